// ----- sv/mbd_pkg.sv -----
// shared constants and types for the magnet button detector
package mbd_pkg;

    localparam int WINDOW_LEN_DEF  = 40;
    localparam int SEGMENT_LEN_DEF = 20;

    localparam int FIELD_W = 16;
    localparam int THR_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [THR_W-1:0] LOW_THR_RESET  = 16'd480;
    localparam logic [THR_W-1:0] HIGH_THR_RESET = 16'd2080;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

    // squared magnitudes: per axis 2*FIELD_W, sum of three axes needs 2 more bits
    localparam int SQ_W   = 2 * FIELD_W;
    localparam int DIST_W = SQ_W + 2;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2
    } event_kind_t;

endpackage

// ----- sv/magnet_button_detector.sv -----
// magnet pull-trigger button detector over a sliding window of magnetometer samples
//
// usage:
//   input channel (in_valid/in_ready) carries one 3-axis sample per transaction.
//   output channel (out_valid/out_ready) returns exactly one result per sample:
//   the button state after that sample and the event (none, pressed, released).
//   configuration: cfg_we writes cfg_data into register cfg_index (0 low
//   threshold, 1 high threshold); write only while the block is idle.
// processing:
//   while fewer than WINDOW_LEN samples are held the block skips the scan and
//   goes to the done state, which raises the result. otherwise it walks
//   min(2*SEGMENT_LEN, held) window entries through one shared squared-distance
//   unit, one entry per cycle, and lets the distance pipeline drain before deciding.
//   the single read port of the window memory sets that rate. in_ready is low
//   while an item is in work and rises together with the result being raised,
//   so the block takes no new sample before it is through with the last one.
// reset: window empty, button released, thresholds back to 480 and 2080.
// stall: the result sits in the output register; a new sample may still be
//   accepted, and its result waits until the output register has been taken.
module magnet_button_detector #(
    parameter int WINDOW_LEN  = mbd_pkg::WINDOW_LEN_DEF,
    parameter int SEGMENT_LEN = mbd_pkg::SEGMENT_LEN_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mbd_pkg::FIELD_W-1:0]     field_x,
    input  logic signed [mbd_pkg::FIELD_W-1:0]     field_y,
    input  logic signed [mbd_pkg::FIELD_W-1:0]     field_z,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   button_down,
    output logic [1:0]                             event_kind,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mbd_pkg::THR_W-1:0]              cfg_data
);
    import mbd_pkg::*;

    // window memory holds WINDOW_LEN+1 samples as a ring
    localparam int WIN_CAP = WINDOW_LEN + 1;
    localparam int PTR_W   = $clog2(WIN_CAP);
    localparam int CNT_W   = $clog2(WIN_CAP + 1);
    localparam int SCAN_MAX = 2 * SEGMENT_LEN;
    localparam int SCAN_W  = $clog2(SCAN_MAX + 1);
    localparam int CMP_W   = (CNT_W > SCAN_W) ? CNT_W : SCAN_W;
    localparam int WORD_W  = 3 * FIELD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t                 state_reg;

    // ring pointers: head is the oldest entry, tail the next write slot
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       tail_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   button_state_reg;
    event_kind_t            pend_event_reg;

    logic [THR_W-1:0]       low_thr_reg;
    logic [THR_W-1:0]       high_thr_reg;
    logic [SQ_W-1:0]        low_sq_reg;
    logic [SQ_W-1:0]        high_sq_reg;

    // baseline is the newest sample
    logic signed [FIELD_W-1:0] base_x_reg;
    logic signed [FIELD_W-1:0] base_y_reg;
    logic signed [FIELD_W-1:0] base_z_reg;

    // scan sequencer
    logic [SCAN_W-1:0]      scan_len_reg;
    logic [SCAN_W-1:0]      issue_idx_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;

    // distance pipeline: stage 1 memory read, stage 2 squares, then fold
    logic                   p1_valid_reg;
    logic                   p1_first_reg;
    logic                   p2_valid_reg;
    logic                   p2_first_reg;
    logic [WORD_W-1:0]      rd_data_reg;
    logic [SQ_W-1:0]        sq_x_reg;
    logic [SQ_W-1:0]        sq_y_reg;
    logic [SQ_W-1:0]        sq_z_reg;

    logic [DIST_W-1:0]      min_first_reg;
    logic [DIST_W-1:0]      max_second_reg;

    // output register
    logic                   out_valid_reg;
    logic                   button_down_reg;
    event_kind_t            event_kind_reg;

    logic [WORD_W-1:0]      window_mem [WIN_CAP];

    // combinational helpers
    logic                   in_fire;
    logic                   full;
    logic [PTR_W-1:0]       tail_next;
    logic [PTR_W-1:0]       head_next;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CMP_W-1:0]       count_ext;
    logic [SCAN_W-1:0]      scan_len_next;
    logic                   issue_go;
    logic                   issue_first;
    logic                   scan_done;
    logic signed [FIELD_W:0] diff_x;
    logic signed [FIELD_W:0] diff_y;
    logic signed [FIELD_W:0] diff_z;
    logic [FIELD_W-1:0]     mag_x;
    logic [FIELD_W-1:0]     mag_y;
    logic [FIELD_W-1:0]     mag_z;
    logic [DIST_W-1:0]      dist_sum;
    logic                   pass;
    logic                   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(WIN_CAP));

    assign tail_next   = (tail_reg == PTR_W'(WIN_CAP - 1)) ? '0 : tail_reg + 1'b1;
    assign head_next   = (head_reg == PTR_W'(WIN_CAP - 1)) ? '0 : head_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(WIN_CAP - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // number of entries to walk: the two segments, clipped at the held count
    assign count_ext     = CMP_W'(count_reg);
    assign scan_len_next = (count_ext < CMP_W'(SCAN_MAX)) ? SCAN_W'(count_ext)
                                                           : SCAN_W'(SCAN_MAX);

    assign issue_go    = (state_reg == ST_SCAN) && (issue_idx_reg != scan_len_reg);
    assign issue_first = (issue_idx_reg < SCAN_W'(SEGMENT_LEN));
    assign scan_done   = (state_reg == ST_SCAN) && (issue_idx_reg == scan_len_reg)
                         && !p1_valid_reg && !p2_valid_reg;

    // stage 2 input: absolute per-axis difference to the baseline
    assign diff_x = $signed({rd_data_reg[3*FIELD_W-1], rd_data_reg[3*FIELD_W-1:2*FIELD_W]})
                    - $signed({base_x_reg[FIELD_W-1], base_x_reg});
    assign diff_y = $signed({rd_data_reg[2*FIELD_W-1], rd_data_reg[2*FIELD_W-1:FIELD_W]})
                    - $signed({base_y_reg[FIELD_W-1], base_y_reg});
    assign diff_z = $signed({rd_data_reg[FIELD_W-1], rd_data_reg[FIELD_W-1:0]})
                    - $signed({base_z_reg[FIELD_W-1], base_z_reg});

    assign mag_x = diff_x[FIELD_W] ? FIELD_W'(-diff_x) : diff_x[FIELD_W-1:0];
    assign mag_y = diff_y[FIELD_W] ? FIELD_W'(-diff_y) : diff_y[FIELD_W-1:0];
    assign mag_z = diff_z[FIELD_W] ? FIELD_W'(-diff_z) : diff_z[FIELD_W-1:0];

    // stage 3: sum of squares folded into min / max
    assign dist_sum = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};

    assign pass = (min_first_reg < {2'b00, low_sq_reg})
                  && (max_second_reg > {2'b00, high_sq_reg});

    assign out_free = !out_valid_reg || out_ready;

    // window memory: one write at acceptance, one registered read per issued scan entry
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            window_mem[tail_reg] <= {field_x, field_y, field_z};
        end
        if (issue_go)
        begin
            rd_data_reg <= window_mem[rd_ptr_reg];
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        sq_x_reg    <= mag_x * mag_x;
        sq_y_reg    <= mag_y * mag_y;
        sq_z_reg    <= mag_z * mag_z;
        low_sq_reg  <= low_thr_reg * low_thr_reg;
        high_sq_reg <= high_thr_reg * high_thr_reg;
        if (in_fire)
        begin
            base_x_reg <= field_x;
            base_y_reg <= field_y;
            base_z_reg <= field_z;
        end
    end

    // sequencer, ring control, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            button_state_reg <= 1'b0;
            pend_event_reg   <= EV_NONE;
            low_thr_reg      <= LOW_THR_RESET;
            high_thr_reg     <= HIGH_THR_RESET;
            scan_len_reg     <= '0;
            issue_idx_reg    <= '0;
            rd_ptr_reg       <= '0;
            p1_valid_reg     <= 1'b0;
            p1_first_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p2_first_reg     <= 1'b0;
            min_first_reg    <= '1;
            max_second_reg   <= '0;
            out_valid_reg    <= 1'b0;
            button_down_reg  <= 1'b0;
            event_kind_reg   <= EV_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                    REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                    default: ;
                endcase
            end

            // in the done state the output register is reloaded below instead
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // pipeline valid bits follow the issue slot
            p1_valid_reg <= issue_go;
            p1_first_reg <= issue_first;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            if (p2_valid_reg)
            begin
                if (p2_first_reg)
                begin
                    if (dist_sum < min_first_reg)
                    begin
                        min_first_reg <= dist_sum;
                    end
                end
                else if (dist_sum > max_second_reg)
                begin
                    max_second_reg <= dist_sum;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        // write at tail; a full ring drops its oldest entry
                        tail_reg <= tail_next;
                        if (full)
                        begin
                            head_reg <= head_next;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    pend_event_reg <= EV_NONE;
                    min_first_reg  <= '1;
                    max_second_reg <= '0;
                    scan_len_reg   <= scan_len_next;
                    issue_idx_reg  <= '0;
                    rd_ptr_reg     <= head_reg;
                    if (count_reg >= CNT_W'(WINDOW_LEN))
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCAN:
                begin
                    if (issue_go)
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                        rd_ptr_reg    <= rd_ptr_next;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (pass)
                    begin
                        // toggle and clear the window
                        button_state_reg <= !button_state_reg;
                        pend_event_reg   <= button_state_reg ? EV_RELEASED : EV_PRESSED;
                        count_reg        <= '0;
                        head_reg         <= tail_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        button_down_reg <= button_state_reg;
                        event_kind_reg  <= pend_event_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign button_down = button_down_reg;
    assign event_kind  = event_kind_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WIN_CAP))
        else $error("window count above capacity");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_kind_reg == EV_PRESSED) |-> button_down_reg)
        else $error("pressed event with button released");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && pass) |=> (count_reg == '0 && head_reg == tail_reg))
        else $error("window not cleared after toggle");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg || p2_valid_reg) |-> state_reg == ST_SCAN)
        else $error("distance pipeline busy outside scan");

endmodule
